// ===== rtl/core/spnts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spnts_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_FRAME_START = 2'd0;
    localparam logic [1:0] KIND_MATRIX_ROW  = 2'd1;
    localparam logic [1:0] KIND_ENEMY       = 2'd2;
    localparam logic [1:0] KIND_FRAME_END   = 2'd3;

    // Result kinds
    localparam logic RES_LISTED = 1'b0;
    localparam logic RES_LOCK   = 1'b1;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCREEN_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_USE_EXT_CTR   = 3'd2;
    localparam t_cfg_idx CFG_CENTER_X      = 3'd3;
    localparam t_cfg_idx CFG_CENTER_Y      = 3'd4;
    localparam t_cfg_idx CFG_RETICLE_RAD   = 3'd5;
    localparam t_cfg_idx CFG_MAX_DISTANCE  = 3'd6;
    localparam t_cfg_idx CFG_HEIGHT_OFFSET = 3'd7;

    // Clip w at or below this (1e-4 in Q16.16) counts as behind the camera
    localparam logic signed [63:0] W_MIN_RAW = 64'sd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         row_index;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
        logic [31:0]        entity_id;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [31:0]        target_id;
        logic [3:0]         slot;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               locked;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/screen_projection_nearest_target_select_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Projects enemy world positions through a 4x4 view-projection matrix, lists the
// visible ones, up to LIST_DEPTH, with their pixel positions and keeps the one
// nearest the reticle centre within the reticle radius for the frame-end lock result.
// Frame-start and matrix-row items are taken without leaving the idle state; a frame
// end passes through S_END, which waits while the output register still holds an
// untaken result. An enemy runs through one shared 34x34 multiplier and a
// one-bit-per-cycle divider: the twelve multiply-accumulates of the matrix product,
// the two pixel fractions (a point on the right or bottom edge skips that division),
// the pixel scaling, then the lock test, which takes in the distance cutoff only
// when it is enabled. The frustum test follows the matrix product, and the list
// step, which can also wait for the output register, comes before the lock test.
// The input stalls until an enemy is done. Enemies rejected early return sooner.

module screen_projection_nearest_target_select_core #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire spnts_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output spnts_pkg::t_out_item      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire spnts_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);
    import spnts_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MMUL = 4'd1;
    localparam logic [3:0] S_MACC = 4'd2;
    localparam logic [3:0] S_TEST = 4'd3;
    localparam logic [3:0] S_DSET = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_SMUL = 4'd6;
    localparam logic [3:0] S_SUSE = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_END  = 4'd9;

    // Multiplier steps after the divider
    localparam logic [3:0] ST_SX  = 4'd0;
    localparam logic [3:0] ST_SY  = 4'd1;
    localparam logic [3:0] ST_WX  = 4'd2;
    localparam logic [3:0] ST_WY  = 4'd3;
    localparam logic [3:0] ST_WZ  = 4'd4;
    localparam logic [3:0] ST_MD  = 4'd5;
    localparam logic [3:0] ST_DX  = 4'd6;
    localparam logic [3:0] ST_DY  = 4'd7;
    localparam logic [3:0] ST_RAD = 4'd8;

    // Configuration
    logic [13:0]        r_scr_w, r_scr_h;
    logic               r_use_ext;
    logic [28:0]        r_ctr_x, r_ctr_y, r_radius;
    logic [30:0]        r_max_dist;
    logic signed [31:0] r_hoff;

    // Frame and camera state
    logic signed [31:0] r_vp [16];
    logic               r_cam_ready;
    logic signed [31:0] r_player [3];
    logic [CW-1:0]      r_listed;
    logic [63:0]        r_best_dsq;
    logic [31:0]        r_best_id;
    logic signed [31:0] r_best_sx, r_best_sy;
    logic signed [31:0] r_best_w [3];
    logic               r_best_valid;

    // Per-enemy working registers
    logic [3:0]         r_state;
    logic [3:0]         r_step;
    logic [1:0]         r_j, r_r;
    logic signed [31:0] r_p [3];
    logic [31:0]        r_id;
    logic signed [63:0] r_clip [4];
    logic signed [63:0] r_prod;
    logic               r_dsel;
    logic [4:0]         r_cnt;
    logic [63:0]        r_rem, r_den;
    logic [31:0]        r_quo;
    logic [32:0]        r_fx, r_fy;
    logic signed [31:0] r_sx, r_sy;
    logic [63:0]        r_wd, r_dsq;

    logic               r_out_valid;
    t_out_item          r_out;

    function automatic logic [32:0] abs33(input logic signed [32:0] d);
        abs33 = d[32] ? 33'(-d) : 33'(d);
    endfunction

    // Saturated enemy y with height offset
    logic signed [32:0] n_ysum;
    logic signed [31:0] n_py;
    always_comb begin
        n_ysum = 33'(i_in_data.value_b) + 33'(r_hoff);
        if (n_ysum > 33'sd2147483647)       n_py = 32'sh7FFFFFFF;
        else if (n_ysum < -33'sd2147483648) n_py = 32'sh80000000;
        else                                n_py = 32'(n_ysum);
    end

    // Reticle centre and offsets
    logic [28:0]        ctr_x, ctr_y;
    logic signed [32:0] dx, dy;
    assign ctr_x = r_use_ext ? r_ctr_x : {r_scr_w, 15'd0};
    assign ctr_y = r_use_ext ? r_ctr_y : {r_scr_h, 15'd0};
    assign dx = $signed({2'b00, r_sx[30:0]}) - $signed({4'b0000, ctr_x});
    assign dy = $signed({2'b00, r_sy[30:0]}) - $signed({4'b0000, ctr_y});

    // Shared multiplier operand selection
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [32:0]        sq_m;
    logic signed [31:0] vp_sel, p_sel;

    assign vp_sel = r_vp[{r_r, r_j}];
    assign p_sel  = r_p[r_r];

    always_comb begin
        case (r_step)
            ST_WX:   sq_m = abs33(33'(r_p[0]) - 33'(r_player[0]));
            ST_WY:   sq_m = abs33(33'(r_p[1]) - 33'(r_player[1]));
            ST_WZ:   sq_m = abs33(33'(r_p[2]) - 33'(r_player[2]));
            ST_MD:   sq_m = {2'b00, r_max_dist};
            ST_DX:   sq_m = abs33(dx);
            ST_DY:   sq_m = abs33(dy);
            ST_RAD:  sq_m = {4'b0000, r_radius};
            default: sq_m = '0;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MMUL) begin
            mul_a = 34'(p_sel);
            mul_b = 34'(vp_sel);
        end else if (r_step == ST_SX) begin
            mul_a = $signed({20'd0, r_scr_w});
            mul_b = $signed({1'b0, r_fx});
        end else if (r_step == ST_SY) begin
            mul_a = $signed({20'd0, r_scr_h});
            mul_b = $signed({1'b0, r_fy});
        end else begin
            mul_a = $signed({1'b0, sq_m});
            mul_b = $signed({1'b0, sq_m});
        end
    end
    assign mul_p = mul_a * mul_b;

    // Divider datapath and helpers
    logic [63:0] rem2;
    logic [64:0] wd_sum;
    logic        out_free;
    logic        in_acc;
    logic        list_room;
    assign rem2      = {r_rem[62:0], 1'b0};
    assign wd_sum    = {1'b0, r_wd} + {1'b0, r_prod};
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_acc    = i_in_valid && !o_in_stall;
    assign list_room = r_listed < CW'(LIST_DEPTH);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w    <= 14'd1920;
            r_scr_h    <= 14'd1080;
            r_use_ext  <= 1'b0;
            r_ctr_x    <= '0;
            r_ctr_y    <= '0;
            r_radius   <= '0;
            r_max_dist <= '0;
            r_hoff     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_scr_w    <= i_cfg_data[13:0];
                CFG_SCREEN_HEIGHT: r_scr_h    <= i_cfg_data[13:0];
                CFG_USE_EXT_CTR:   r_use_ext  <= i_cfg_data[0];
                CFG_CENTER_X:      r_ctr_x    <= i_cfg_data[28:0];
                CFG_CENTER_Y:      r_ctr_y    <= i_cfg_data[28:0];
                CFG_RETICLE_RAD:   r_radius   <= i_cfg_data[28:0];
                CFG_MAX_DISTANCE:  r_max_dist <= i_cfg_data[30:0];
                CFG_HEIGHT_OFFSET: r_hoff     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_cam_ready  <= 1'b0;
            r_listed     <= '0;
            r_best_dsq   <= '1;
            r_best_id    <= '0;
            r_best_sx    <= '0;
            r_best_sy    <= '0;
            r_best_valid <= 1'b0;
            for (int k = 0; k < 16; k++) r_vp[k] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_player[k] <= '0;
                r_best_w[k] <= '0;
            end
        end else begin
            // drop the result once taken
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.kind)
                            KIND_FRAME_START: begin
                                r_player[0]  <= i_in_data.value_a;
                                r_player[1]  <= i_in_data.value_b;
                                r_player[2]  <= i_in_data.value_c;
                                r_cam_ready  <= 1'b0;
                                r_listed     <= '0;
                                r_best_dsq   <= '1;
                                r_best_id    <= '0;
                                r_best_sx    <= '0;
                                r_best_sy    <= '0;
                                r_best_w[0]  <= '0;
                                r_best_w[1]  <= '0;
                                r_best_w[2]  <= '0;
                                r_best_valid <= 1'b0;
                            end
                            KIND_MATRIX_ROW: begin
                                r_vp[{i_in_data.row_index, 2'd0}] <= i_in_data.value_a;
                                r_vp[{i_in_data.row_index, 2'd1}] <= i_in_data.value_b;
                                r_vp[{i_in_data.row_index, 2'd2}] <= i_in_data.value_c;
                                r_vp[{i_in_data.row_index, 2'd3}] <= i_in_data.value_d;
                                if (i_in_data.row_index == 2'd3) r_cam_ready <= 1'b1;
                            end
                            KIND_ENEMY: begin
                                if (r_cam_ready && r_scr_w != '0 && r_scr_h != '0) begin
                                    r_p[0] <= i_in_data.value_a;
                                    r_p[1] <= n_py;
                                    r_p[2] <= i_in_data.value_c;
                                    r_id   <= i_in_data.entity_id;
                                    for (int k = 0; k < 4; k++)
                                        r_clip[k] <= 64'(r_vp[12 + k]);
                                    r_j     <= '0;
                                    r_r     <= '0;
                                    r_state <= S_MMUL;
                                end
                            end
                            default: r_state <= S_END;
                        endcase
                    end
                end

                // Matrix product: multiply, then accumulate the floored term
                S_MMUL: begin
                    r_prod  <= 64'(mul_p);
                    r_state <= S_MACC;
                end
                S_MACC: begin
                    r_clip[r_j] <= r_clip[r_j] + (r_prod >>> 16);
                    r_state     <= S_MMUL;
                    if (r_r == 2'd2) begin
                        r_r <= '0;
                        r_j <= r_j + 2'd1;
                        if (r_j == 2'd3) r_state <= S_TEST;
                    end else begin
                        r_r <= r_r + 2'd1;
                    end
                end

                // Behind camera, depth and frustum tests
                S_TEST: begin
                    if (r_clip[3] <= W_MIN_RAW ||
                        r_clip[2] < 0 || r_clip[2] > r_clip[3] ||
                        r_clip[0] < -r_clip[3] || r_clip[0] > r_clip[3] ||
                        r_clip[1] < -r_clip[3] || r_clip[1] > r_clip[3]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_dsel  <= 1'b0;
                        r_state <= S_DSET;
                    end
                end

                // Pixel fraction: load the divider, or take the edge value
                S_DSET: begin
                    r_den <= 64'(r_clip[3] <<< 1);
                    r_rem <= r_dsel ? 64'(r_clip[3] - r_clip[1])
                                    : 64'(r_clip[0] + r_clip[3]);
                    r_quo <= '0;
                    r_cnt <= '0;
                    if ((r_dsel ? (r_clip[3] - r_clip[1]) : (r_clip[0] + r_clip[3]))
                        >= (r_clip[3] <<< 1)) begin
                        if (r_dsel) begin
                            r_fy    <= 33'h1_0000_0000;
                            r_step  <= ST_SX;
                            r_state <= S_SMUL;
                        end else begin
                            r_fx   <= 33'h1_0000_0000;
                            r_dsel <= 1'b1;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem2 >= r_den) begin
                        r_rem <= rem2 - r_den;
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        if (r_dsel) begin
                            r_fy    <= {1'b0, r_quo[30:0], (rem2 >= r_den)};
                            r_step  <= ST_SX;
                            r_state <= S_SMUL;
                        end else begin
                            r_fx    <= {1'b0, r_quo[30:0], (rem2 >= r_den)};
                            r_dsel  <= 1'b1;
                            r_state <= S_DSET;
                        end
                    end
                end

                // Scaling and squaring steps through the shared multiplier
                S_SMUL: begin
                    r_prod  <= 64'(mul_p);
                    r_state <= S_SUSE;
                end
                S_SUSE: begin
                    r_state <= S_SMUL;
                    r_step  <= r_step + 4'd1;
                    case (r_step)
                        ST_SX: r_sx <= $signed(r_prod[47:16]);
                        ST_SY: begin
                            r_sy    <= $signed(r_prod[47:16]);
                            r_state <= S_EMIT;
                        end
                        ST_WX: r_wd <= r_prod;
                        ST_WY, ST_WZ: r_wd <= wd_sum[64] ? '1 : wd_sum[63:0];
                        ST_MD: if (r_wd > r_prod) r_state <= S_IDLE;
                        ST_DX: r_dsq <= r_prod;
                        ST_DY: r_dsq <= r_dsq + r_prod;
                        ST_RAD: begin
                            r_state <= S_IDLE;
                            if (r_dsq <= r_prod && r_dsq < r_best_dsq) begin
                                r_best_dsq   <= r_dsq;
                                r_best_id    <= r_id;
                                r_best_sx    <= r_sx;
                                r_best_sy    <= r_sy;
                                r_best_w[0]  <= r_p[0];
                                r_best_w[1]  <= r_p[1];
                                r_best_w[2]  <= r_p[2];
                                r_best_valid <= 1'b1;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end

                // List the target while there is room, then go on to the lock test
                S_EMIT: begin
                    if (!list_room || out_free) begin
                        if (list_room) begin
                            r_out_valid       <= 1'b1;
                            r_out.result_kind <= RES_LISTED;
                            r_out.target_id   <= r_id;
                            r_out.slot        <= 4'(r_listed);
                            r_out.screen_x    <= r_sx;
                            r_out.screen_y    <= r_sy;
                            r_out.world_x     <= '0;
                            r_out.world_y     <= '0;
                            r_out.world_z     <= '0;
                            r_out.locked      <= 1'b0;
                            r_listed          <= r_listed + CW'(1);
                        end
                        r_step  <= (r_max_dist != '0) ? ST_WX : ST_DX;
                        r_state <= S_SMUL;
                    end
                end

                // Frame end: report the lock
                S_END: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.result_kind <= RES_LOCK;
                        r_out.slot        <= '0;
                        r_out.target_id   <= r_best_valid ? r_best_id : '0;
                        r_out.screen_x    <= r_best_valid ? r_best_sx : '0;
                        r_out.screen_y    <= r_best_valid ? r_best_sy : '0;
                        r_out.world_x     <= r_best_valid ? r_best_w[0] : '0;
                        r_out.world_y     <= r_best_valid ? r_best_w[1] : '0;
                        r_out.world_z     <= r_best_valid ? r_best_w[2] : '0;
                        r_out.locked      <= r_best_valid;
                        r_state           <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The list never grows past its depth
    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_listed <= CW'(LIST_DEPTH))
        else $error("listed count beyond list depth");

    // Without a lock the best distance stays at its cleared value
    a_best_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_best_valid |-> (r_best_dsq == '1))
        else $error("best distance set without a lock");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    // A listed result never carries the locked flag or world x and z
    a_listed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == RES_LISTED) |->
        (!r_out.locked && r_out.world_x == '0 && r_out.world_z == '0))
        else $error("listed result carries lock fields");

    // A new result is loaded only when the previous one has been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import spnts_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int     SETTLE      = 200;
    localparam longint ONE         = 64'sd65536;

    // Tracks what the selector should report: listed targets and frame locks
    class lock_scoreboard;
        longint unsigned scr_w, scr_h, use_ext, ctr_x, ctr_y, radius, max_dist;
        longint          hoff;
        longint          mat [16];
        bit              cam_ready;
        longint          player [3];
        int              listed;
        longint unsigned best_dsq;
        logic [31:0]     best_id;
        longint          best_scr [2];
        longint          best_wld [3];
        bit              best_valid;
        t_out_item       expected_targets [$];
        int              mismatches;
        int              checked;
        int              locks;

        function new();
            scr_w = 1920; scr_h = 1080; use_ext = 0;
            ctr_x = 0; ctr_y = 0; radius = 0; max_dist = 0; hoff = 0;
            foreach (mat[i]) mat[i] = 0;
            cam_ready = 0;
            foreach (player[i]) player[i] = 0;
            clear_frame();
            mismatches = 0; checked = 0; locks = 0;
        endfunction

        function void clear_frame();
            listed = 0;
            best_dsq = '1;
            best_id = 0;
            best_scr[0] = 0; best_scr[1] = 0;
            foreach (best_wld[i]) best_wld[i] = 0;
            best_valid = 0;
        endfunction

        function void set_cfg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w = data[13:0];
                CFG_SCREEN_HEIGHT: scr_h = data[13:0];
                CFG_USE_EXT_CTR:   use_ext = data[0];
                CFG_CENTER_X:      ctr_x = data[28:0];
                CFG_CENTER_Y:      ctr_y = data[28:0];
                CFG_RETICLE_RAD:   radius = data[28:0];
                CFG_MAX_DISTANCE:  max_dist = data[30:0];
                CFG_HEIGHT_OFFSET: hoff = longint'($signed(data));
                default: ;
            endcase
        endfunction

        // floor(a * 2^32 / b) for a below b, else 2^32 (0 when b is zero), one quotient bit per step
        function longint unsigned pixel_frac(longint unsigned a, longint unsigned b);
            longint unsigned q, r;
            q = 0; r = a;
            if (b == 0) return 0;
            if (a >= b) return 64'd1 << 32;
            for (int i = 0; i < 32; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= b) begin
                    r = r - b;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        // square of the magnitude, wrapping at 64 bits
        function longint unsigned mag_sq(longint d);
            longint unsigned m;
            m = (d < 0) ? longint'(-d) : d;
            return m * m;
        endfunction

        function longint unsigned add_sat(longint unsigned a, longint unsigned b);
            longint unsigned s;
            s = a + b;
            return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
        endfunction

        function void note_item(t_in_item it);
            longint p [3];
            longint clip [4];
            longint s, sx, sy, cx, cy;
            longint unsigned fx, fy, dsq, wd;
            t_out_item res;
            case (it.kind)
                KIND_FRAME_START: begin
                    player[0] = it.value_a; player[1] = it.value_b; player[2] = it.value_c;
                    cam_ready = 0;
                    clear_frame();
                end
                KIND_MATRIX_ROW: begin
                    mat[it.row_index * 4 + 0] = it.value_a;
                    mat[it.row_index * 4 + 1] = it.value_b;
                    mat[it.row_index * 4 + 2] = it.value_c;
                    mat[it.row_index * 4 + 3] = it.value_d;
                    if (it.row_index == 2'd3) cam_ready = 1;
                end
                KIND_FRAME_END: begin
                    res = '0;
                    res.result_kind = RES_LOCK;
                    if (best_valid) begin
                        res.target_id = best_id;
                        res.screen_x = best_scr[0]; res.screen_y = best_scr[1];
                        res.world_x = best_wld[0]; res.world_y = best_wld[1];
                        res.world_z = best_wld[2];
                        res.locked = 1'b1;
                    end
                    expected_targets.push_back(res);
                end
                default: begin
                    if (!cam_ready || scr_w == 0 || scr_h == 0) return;
                    p[0] = it.value_a;
                    p[1] = longint'(it.value_b) + hoff;
                    if (p[1] > 64'sd2147483647) p[1] = 64'sd2147483647;
                    if (p[1] < -64'sd2147483648) p[1] = -64'sd2147483648;
                    p[2] = it.value_c;
                    for (int j = 0; j < 4; j++) begin
                        s = mat[12 + j];
                        for (int r = 0; r < 3; r++) s += (p[r] * mat[r * 4 + j]) >>> 16;
                        clip[j] = s;
                    end
                    // drop points behind the camera or outside the view volume
                    if (clip[3] <= 6) return;
                    if (clip[2] < 0 || clip[2] > clip[3]) return;
                    if (clip[0] < -clip[3] || clip[0] > clip[3]) return;
                    if (clip[1] < -clip[3] || clip[1] > clip[3]) return;
                    fx = pixel_frac(clip[0] + clip[3], 2 * clip[3]);
                    fy = pixel_frac(clip[3] - clip[1], 2 * clip[3]);
                    sx = (scr_w * fx) >> 16;
                    sy = (scr_h * fy) >> 16;
                    if (listed < 16) begin
                        res = '0;
                        res.result_kind = RES_LISTED;
                        res.target_id = it.entity_id;
                        res.slot = listed[3:0];
                        res.screen_x = sx[31:0]; res.screen_y = sy[31:0];
                        expected_targets.push_back(res);
                        listed++;
                    end
                    if (max_dist > 0) begin
                        wd = mag_sq(p[0] - player[0]);
                        wd = add_sat(wd, mag_sq(p[1] - player[1]));
                        wd = add_sat(wd, mag_sq(p[2] - player[2]));
                        if (wd > max_dist * max_dist) return;
                    end
                    cx = use_ext ? ctr_x : (scr_w << 15);
                    cy = use_ext ? ctr_y : (scr_h << 15);
                    dsq = mag_sq(sx - cx) + mag_sq(sy - cy);
                    if (dsq > radius * radius) return;
                    if (dsq < best_dsq) begin
                        best_dsq = dsq;
                        best_id = it.entity_id;
                        best_scr[0] = sx; best_scr[1] = sy;
                        best_wld[0] = p[0]; best_wld[1] = p[1]; best_wld[2] = p[2];
                        best_valid = 1;
                    end
                end
            endcase
        endfunction

        function void check_result(t_out_item act);
            t_out_item exp_r;
            if (expected_targets.size() == 0) begin
                $display("%0t: unexpected result %p", $time, act);
                mismatches++;
                return;
            end
            exp_r = expected_targets.pop_front();
            checked++;
            if (act.result_kind == RES_LOCK && act.locked) locks++;
            if (act.result_kind != exp_r.result_kind || act.target_id != exp_r.target_id ||
                act.slot != exp_r.slot || act.screen_x != exp_r.screen_x ||
                act.screen_y != exp_r.screen_y || act.world_x != exp_r.world_x ||
                act.world_y != exp_r.world_y || act.world_z != exp_r.world_z ||
                act.locked != exp_r.locked) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_index;
    logic [31:0] i_cfg_data;

    lock_scoreboard sb;
    longint cycles;
    int     send_idle_pct;
    int     stall_pct;
    int     hold_requests;
    int     hold_served;
    int     hold_left;
    int     items_sent;

    screen_projection_nearest_target_select_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= 3000;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    function automatic t_in_item make_item(logic [1:0] kind, logic [1:0] row,
                                           logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d,
                                           logic [31:0] id);
        t_in_item it;
        it.kind = kind; it.row_index = row;
        it.value_a = a; it.value_b = b; it.value_c = c; it.value_d = d;
        it.entity_id = id;
        return it;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_cfg(idx, data);
        @(posedge i_clk);
    endtask

    // Wait for every expected result, then let a rejected enemy finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_targets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_camera();
        longint near;
        near = $urandom_range(0, 65536);
        send(make_item(KIND_MATRIX_ROW, 2'd0, $urandom_range(32768, 131072), 0, 0, 0,
                       $urandom));
        send(make_item(KIND_MATRIX_ROW, 2'd1, 0, $urandom_range(32768, 131072), 0, 0,
                       $urandom));
        send(make_item(KIND_MATRIX_ROW, 2'd2, 0, 0, ONE, ONE, $urandom));
        send(make_item(KIND_MATRIX_ROW, 2'd3, $urandom_range(0, 131072) - 65536,
                       $urandom_range(0, 131072) - 65536, -near, 0, $urandom));
    endtask

    task automatic send_enemy();
        longint z, x, y, b, span;
        if ($urandom_range(19) == 0) z = longint'($signed($urandom)) >>> $urandom_range(31);
        else z = $urandom_range(0, 150 * 65536);
        span = (z < 0 ? -z : z) + 1;
        x = longint'($urandom_range(0, span * 9 / 4)) - span * 9 / 8;
        y = longint'($urandom_range(0, span * 9 / 4)) - span * 9 / 8;
        b = y - sb.hoff;
        if (b > 64'sd2147483647) b = 64'sd2147483647;
        if (b < -64'sd2147483648) b = -64'sd2147483648;
        send(make_item(KIND_ENEMY, $urandom, x, b, z, $urandom, $urandom));
    endtask

    // One frame: mostly well formed, now and then noise or a broken camera load
    task automatic run_frame();
        int n;
        send(make_item(KIND_FRAME_START, $urandom,
                       $urandom_range(0, 100 * 65536) - 50 * 65536,
                       $urandom_range(0, 100 * 65536) - 50 * 65536,
                       $urandom_range(0, 100 * 65536) - 50 * 65536, $urandom, $urandom));
        if ($urandom_range(9) != 0) load_camera();
        else send(make_item(KIND_MATRIX_ROW, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom));
        n = ($urandom_range(5) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send(make_item($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom));
            else send_enemy();
        end
        send(make_item(KIND_FRAME_END, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom));
        if ($urandom_range(7) == 0)
            send(make_item(KIND_FRAME_END, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic set_phase_cfg(int ph);
        case (ph)
            1: begin
                write_cfg(CFG_SCREEN_WIDTH, 8192);
                write_cfg(CFG_SCREEN_HEIGHT, 8192);
                write_cfg(CFG_RETICLE_RAD, 32'h1FFF_FFFF);
            end
            2: begin
                write_cfg(CFG_SCREEN_WIDTH, 1);
                write_cfg(CFG_SCREEN_HEIGHT, 1);
                write_cfg(CFG_USE_EXT_CTR, 1);
                write_cfg(CFG_CENTER_X, 0);
                write_cfg(CFG_CENTER_Y, 32'h1FFF_FFFF);
            end
            3: begin
                write_cfg(CFG_SCREEN_WIDTH, 1920);
                write_cfg(CFG_SCREEN_HEIGHT, 1080);
                write_cfg(CFG_USE_EXT_CTR, 0);
                write_cfg(CFG_RETICLE_RAD, 300 * 65536);
                write_cfg(CFG_MAX_DISTANCE, 100 * 65536);
                write_cfg(CFG_HEIGHT_OFFSET, 2 * 65536);
            end
            4: begin
                write_cfg(CFG_HEIGHT_OFFSET, 32'h7FFF_FFFF);
                write_cfg(CFG_MAX_DISTANCE, 32'h7FFF_FFFF);
            end
            5: begin
                write_cfg(CFG_HEIGHT_OFFSET, 32'h8000_0000);
                write_cfg(CFG_SCREEN_WIDTH, 0);
            end
            6: begin
                write_cfg(CFG_SCREEN_WIDTH, $urandom_range(1, 8192));
                write_cfg(CFG_SCREEN_HEIGHT, $urandom_range(1, 8192));
                write_cfg(CFG_USE_EXT_CTR, 1);
                write_cfg(CFG_CENTER_X, $urandom);
                write_cfg(CFG_CENTER_Y, $urandom);
                write_cfg(CFG_RETICLE_RAD, $urandom);
                write_cfg(CFG_MAX_DISTANCE, 0);
                write_cfg(CFG_HEIGHT_OFFSET, $urandom_range(0, 20 * 65536) - 10 * 65536);
            end
            default: begin
                write_cfg(CFG_SCREEN_WIDTH, 1280);
                write_cfg(CFG_SCREEN_HEIGHT, 720);
                write_cfg(CFG_CENTER_X, 640 * 65536);
                write_cfg(CFG_CENTER_Y, 360 * 65536);
                write_cfg(CFG_RETICLE_RAD, 200 * 65536);
                write_cfg(CFG_MAX_DISTANCE, 1);
                write_cfg(CFG_HEIGHT_OFFSET, 0);
            end
        endcase
    endtask

    initial begin
        int phase_start;
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SCREEN_WIDTH;
        i_cfg_data = '0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: camera not ready, centre lock, edges, behind camera, extremes
        send(make_item(KIND_FRAME_START, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        send(make_item(KIND_ENEMY, 0, 0, 0, 10 * 65536, 0, 1));
        send(make_item(KIND_FRAME_END, 0, 0, 0, 0, 0, 0));
        send(make_item(KIND_MATRIX_ROW, 2'd0, ONE, 0, 0, 0, 0));
        send(make_item(KIND_MATRIX_ROW, 2'd1, 0, ONE, 0, 0, 0));
        send(make_item(KIND_MATRIX_ROW, 2'd2, 0, 0, ONE, ONE, 0));
        send(make_item(KIND_MATRIX_ROW, 2'd3, 0, 0, -4096, 0, 0));
        send(make_item(KIND_ENEMY, 2'd3, 0, 0, 10 * 65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_item(KIND_ENEMY, 0, 10 * 65536, 10 * 65536, 10 * 65536, 0, 2));
        send(make_item(KIND_ENEMY, 0, -10 * 65536, -10 * 65536, 10 * 65536, 0, 3));
        send(make_item(KIND_ENEMY, 0, 0, 0, 0, 0, 4));
        send(make_item(KIND_ENEMY, 0, 0, 0, 3, 0, 5));
        send(make_item(KIND_ENEMY, 0, 0, 0, 1024, 0, 6));
        send(make_item(KIND_ENEMY, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 7));
        send(make_item(KIND_FRAME_END, 0, 0, 0, 0, 0, 0));
        send(make_item(KIND_FRAME_END, 2'd3, '1, '1, '1, '1, '1));
        send(make_item(KIND_MATRIX_ROW, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 0));
        send(make_item(KIND_ENEMY, 0, ONE, ONE, ONE, 0, 8));
        send(make_item(KIND_FRAME_END, 0, 0, 0, 0, 0, 0));
        drain();

        // Random phases; each after the first writes its own settings, and they cycle through four idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            if (ph != 0) set_phase_cfg(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 88; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            if (ph == 3) hold_requests = hold_requests + 1;
            phase_start = items_sent;
            while (items_sent - phase_start < 85) run_frame();
            drain();
        end

        $display("sent %0d items over eight settings; %0d results checked, %0d locks",
                 items_sent, sb.checked, sb.locks);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/spnts_pkg.sv
rtl/core/screen_projection_nearest_target_select_core.sv
test/testbench.sv
